>>> src/positional_linked_list_engine_defines.svh
// Assertion macros for the positional linked-list engine.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PLL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define PLL_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/pll_pkg.sv
// Shared constants, codes and types of the positional linked-list engine.
`timescale 1ns / 1ps
package pll_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 32;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int ELEM_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ELEM_W + STAT_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_INS_POS  = 3'd2,
        KIND_DEL_POS  = 3'd3,
        KIND_DUMP     = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

>>> src/positional_linked_list_engine.sv
// Head and tail inserts and all error replies go from decode straight to the response state;
// insert at position p walks the list, then links the new node in and responds, and delete at
// position p walks to the node, unlinks it and responds. A dump of n elements gives one result
// per cycle while the output is not stalled. Throughput: one request at a time; the next
// transfer is taken only once the engine is idle again, after the last result is registered.
// Synchronous active-low reset empties the list; node memories keep no reset value.
`timescale 1ns / 1ps
`include "positional_linked_list_engine_defines.svh"
module positional_linked_list_engine
    import pll_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // position, value, zero pad
    input  logic [KIND_W-1:0]    i_s_tuser,   // kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // element, status, length, zero pad
    output logic                 o_m_tlast
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_WALK   = 6'b000100,
        S_LINK   = 6'b001000,
        S_DUMP   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_head, n_head;
    logic [IDX_W-1:0]           r_tail, n_tail;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CAPACITY-1:0]        r_used, n_used;
    logic [IDX_W-1:0]           r_cur, n_cur;
    logic [IDX_W-1:0]           r_prev, n_prev;
    logic [IDX_W-1:0]           r_steps, n_steps;
    logic [DATA_BITS-1:0]       r_res_elem, n_res_elem;
    t_status                    r_res_status, n_res_status;

    logic [KIND_W-1:0]          r_kind;
    logic [POS_W-1:0]           r_pos;
    logic signed [VALUE_W-1:0]  r_value;

    logic                       r_out_valid, n_out_valid;
    logic [DATA_BITS-1:0]       r_out_elem, n_out_elem;
    t_status                    r_out_status, n_out_status;
    logic [LEN_W-1:0]           r_out_len, n_out_len;
    logic                       r_out_last, n_out_last;

    logic [DATA_BITS-1:0]       r_val_mem [CAPACITY];
    logic [IDX_W-1:0]           r_link_mem [CAPACITY];
    logic [DATA_BITS-1:0]       r_val_q;
    logic [IDX_W-1:0]           r_link_q;

    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       val_we;
    logic [IDX_W-1:0]           val_wa;
    logic [DATA_BITS-1:0]       val_wd;
    logic                       link_we;
    logic [IDX_W-1:0]           link_wa;
    logic [IDX_W-1:0]           link_wd;

    logic [IDX_W-1:0]           free_idx;
    logic [CMP_W-1:0]           pos_c;
    logic [CMP_W-1:0]           cnt_c;
    logic                       in_xfer;
    logic                       out_free;
    logic signed [ELEM_W-1:0]   out_elem_ext;

    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign pos_c      = CMP_W'(r_pos);
    assign cnt_c      = CMP_W'(r_count);

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_used       = r_used;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_res_elem   = r_res_elem;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_elem   = r_out_elem;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_link_q;
        val_we       = 1'b0;
        val_wa       = free_idx;
        val_wd       = DATA_BITS'(r_value);
        link_we      = 1'b0;
        link_wa      = free_idx;
        link_wd      = r_link_q;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_elem   = '0;
                n_res_status = ST_OK;
                n_state      = S_RESP;
                case (r_kind)
                    KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
                        if (cnt_c == CMP_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                        end else if (r_kind == KIND_INS_POS &&
                                     (pos_c == '0 || pos_c > cnt_c + CMP_W'(1))) begin
                            n_res_status = ST_RANGE;
                        end else if (r_kind == KIND_INS_HEAD ||
                                     (r_kind == KIND_INS_POS && pos_c == CMP_W'(1))) begin
                            val_we           = 1'b1;
                            link_we          = 1'b1;
                            link_wa          = free_idx;
                            link_wd          = r_head;
                            n_head           = free_idx;
                            if (r_count == '0) begin
                                n_tail = free_idx;
                            end
                            n_count          = r_count + CNT_W'(1);
                            n_used[free_idx] = 1'b1;
                        end else if (r_kind == KIND_INS_TAIL ||
                                     pos_c == cnt_c + CMP_W'(1)) begin
                            val_we = 1'b1;
                            if (r_count == '0) begin
                                n_head = free_idx;
                            end else begin
                                link_we = 1'b1;
                                link_wa = r_tail;
                                link_wd = free_idx;
                            end
                            n_tail           = free_idx;
                            n_count          = r_count + CNT_W'(1);
                            n_used[free_idx] = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = IDX_W'(pos_c - CMP_W'(2));
                            n_state = S_WALK;
                        end
                    end
                    KIND_DEL_POS: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else if (pos_c == '0 || pos_c > cnt_c) begin
                            n_res_status = ST_RANGE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = IDX_W'(pos_c - CMP_W'(1));
                            n_state = S_WALK;
                        end
                    end
                    KIND_DUMP: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_steps = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_DUMP;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                if (r_steps != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_link_q;
                    n_prev  = r_cur;
                    n_cur   = r_link_q;
                    n_steps = r_steps - IDX_W'(1);
                end else if (r_kind == KIND_INS_POS) begin
                    val_we  = 1'b1;
                    link_we = 1'b1;
                    link_wa = free_idx;
                    link_wd = r_link_q;
                    n_state = S_LINK;
                end else begin
                    n_res_elem = r_val_q;
                    if (pos_c == CMP_W'(1)) begin
                        n_head = r_link_q;
                    end else begin
                        link_we = 1'b1;
                        link_wa = r_prev;
                        link_wd = r_link_q;
                        if (r_cur == r_tail) begin
                            n_tail = r_prev;
                        end
                    end
                    n_used[r_cur] = 1'b0;
                    n_count       = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_state = S_RESP;
                end
            end
            S_LINK: begin
                link_we          = 1'b1;
                link_wa          = r_cur;
                link_wd          = free_idx;
                n_used[free_idx] = 1'b1;
                n_count          = r_count + CNT_W'(1);
                n_state          = S_RESP;
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_elem   = r_val_q;
                    n_out_status = ST_OK;
                    n_out_len    = LEN_W'(r_count);
                    n_out_last   = (r_steps == '0);
                    if (r_steps == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_link_q;
                        n_cur   = r_link_q;
                        n_steps = r_steps - IDX_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_elem   = r_res_elem;
                    n_out_status = r_res_status;
                    n_out_len    = LEN_W'(r_count);
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_res_elem   <= n_res_elem;
        r_res_status <= n_res_status;
        r_out_elem   <= n_out_elem;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
        if (in_xfer) begin
            r_kind  <= i_s_tuser;
            r_pos   <= i_s_tdata[POS_W-1:0];
            r_value <= i_s_tdata[POS_W +: VALUE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_wa] <= val_wd;
        end
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (rd_en) begin
            r_val_q  <= r_val_mem[rd_addr];
            r_link_q <= r_link_mem[rd_addr];
        end
    end

    assign out_elem_ext = ELEM_W'($signed(r_out_elem));
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tlast    = r_out_last;
    assign o_m_tdata    = M_TDATA_W'({r_out_len, r_out_status, out_elem_ext});

    `PLL_ASSERT_ALWAYS(a_used_matches_count, $countones(r_used) == int'(r_count), "Slot map disagrees with element count.")
    `PLL_ASSERT_IMPLY(a_empty_resets_ends, r_count == '0, r_head == '0 && r_tail == '0, "Empty list keeps stale head or tail.")
    `PLL_ASSERT_IMPLY(a_dump_within_list, r_state == S_DUMP, CNT_W'(r_steps) < r_count, "Dump walk runs past the list end.")

endmodule
